### hw/rtl/bdiv_pkg.sv
// Shared types, command codes and divisor tables for the baud rate divider.
// No dependencies; used by baud_rate_divider.
`default_nettype none

package bdiv_pkg;

  localparam int COUNT_BITS    = 13;
  localparam int TABLE_ENTRIES = 16;
  localparam int SEL_BITS      = $clog2(TABLE_ENTRIES);
  localparam int DIV_BITS      = 12;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [COUNT_BITS-1:0] RESET_DELAY_DEFAULT  = 13'd930;
  localparam logic [COUNT_BITS-1:0] SELECT_DELAY_DEFAULT = 13'd5187;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_EDGE   = 2'd1,
    CMD_RESET  = 2'd2,
    CMD_SELECT = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TABLE_VARIANT = 2'd0,
    CFG_RESET_DELAY   = 2'd1,
    CFG_SELECT_DELAY  = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]          command;
    logic [SEL_BITS-1:0] rate_select;
  } in_item_t;

  typedef struct packed {
    logic baud_out;
    logic level_changed;
  } out_item_t;

  // Doubled divisor for a select; zero means external frequency.
  function automatic logic [DIV_BITS-1:0] divisor(input logic variant,
                                                  input logic [SEL_BITS-1:0] sel);
    logic [DIV_BITS-1:0] d;
    begin
      case (sel)
        4'd0:    d = 12'd0;
        4'd1:    d = 12'd2304;
        4'd2:    d = variant ? 12'd576 : 12'd1536;
        4'd3:    d = 12'd1048;
        4'd4:    d = 12'd857;
        4'd5:    d = 12'd768;
        4'd6:    d = 12'd384;
        4'd7:    d = 12'd192;
        4'd8:    d = 12'd128;
        4'd9:    d = 12'd96;
        4'd10:   d = 12'd64;
        4'd11:   d = 12'd48;
        4'd12:   d = 12'd32;
        4'd13:   d = 12'd24;
        4'd14:   d = variant ? 12'd1536 : 12'd16;
        default: d = 12'd12;
      endcase
      return d;
    end
  endfunction

  // Length in half-clocks of the phase that has just been entered.
  function automatic logic [COUNT_BITS-1:0] phase_length(input logic [DIV_BITS-1:0] d,
                                                        input logic [1:0] phase);
    logic [COUNT_BITS:0] dx;
    logic [COUNT_BITS:0] len;
    begin
      dx = {{(COUNT_BITS+1-DIV_BITS){1'b0}}, d};
      case (phase)
        2'd0:    len = ((dx & ~(COUNT_BITS+1)'(2)) >> 1) | (dx & (COUNT_BITS+1)'(1));
        2'd1:    len = ((dx + (COUNT_BITS+1)'(2)) >> 2) << 1;
        2'd2:    len = ((dx >> 2) + (dx & (COUNT_BITS+1)'(1))) << 1;
        default: len = ((dx + (dx & (COUNT_BITS+1)'(2))) >> 1)
                       - ((dx & (COUNT_BITS+1)'(1)) << 1);
      endcase
      return len[COUNT_BITS-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/baud_rate_divider.sv
// Programmable baud rate divider: command input register, state update and result register.
// Depends on bdiv_pkg for the item types, command codes and divisor tables.
`default_nettype none

// Each accepted transfer carries one command: a half-clock tick, an external
// half-period edge, a reset pulse or a write of the 4-bit rate select. The
// block produces exactly one result per command, holding the output level
// after the command and a flag that is set when the command advanced the
// output phase. Commands are taken one per cycle unless the result register
// stalls: the command is captured in an input register, then the divider
// state (phase, half-clock countdown, external wait flag, select and level)
// is updated and the result is written to the output register once that
// register can take it. The input side keeps accepting while a finished
// result waits, as long as the output register is free or being drained.
// Configuration (table variant and the two start delays) is to be written
// through the cfg_ port while the block is idle; the block does not enforce
// this. The start delays take effect at the next reset pulse or select
// change.
module baud_rate_divider (
  input  wire logic                             clk,
  input  wire logic                             rst_n,

  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire bdiv_pkg::in_item_t               in_data,

  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output bdiv_pkg::out_item_t                   out_data,

  input  wire logic                             cfg_we,
  input  wire logic [bdiv_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [bdiv_pkg::COUNT_BITS-1:0]  cfg_wdata
);

  // Configuration registers.
  logic                            table_variant_r;
  logic [bdiv_pkg::COUNT_BITS-1:0] reset_delay_r;
  logic [bdiv_pkg::COUNT_BITS-1:0] select_delay_r;

  // Input register.
  logic                 in_valid_r;
  bdiv_pkg::in_item_t   in_data_r;

  // Divider state.
  logic [1:0]                      phase_r,   phase_nxt;
  logic [bdiv_pkg::COUNT_BITS-1:0] left_r,    left_nxt;
  logic                            wait_ext_r, wait_ext_nxt;
  logic [bdiv_pkg::SEL_BITS-1:0]   select_r,  select_nxt;
  logic                            level_r,   level_nxt;
  logic                            changed;

  // Result register.
  logic                 out_valid_r;
  bdiv_pkg::out_item_t  out_data_r;

  logic                            advance;
  logic                            step;
  logic [1:0]                      phase_inc;
  logic [bdiv_pkg::DIV_BITS-1:0]   div;
  bdiv_pkg::cmd_t                  cmd;

  // The result register can take a new result when it is empty or its
  // current transfer completes in this cycle.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign step     = in_valid_r && advance;

  assign cmd       = bdiv_pkg::cmd_t'(in_data_r.command);
  assign phase_inc = phase_r + 2'd1;
  assign div       = bdiv_pkg::divisor(table_variant_r, select_r);

  always_comb begin
    phase_nxt    = phase_r;
    left_nxt     = left_r;
    wait_ext_nxt = wait_ext_r;
    select_nxt   = select_r;
    level_nxt    = level_r;
    changed      = 1'b0;

    // A phase advance happens on a tick whose countdown has run out, or on
    // an external edge while the block waits for one.
    case (cmd)
      bdiv_pkg::CMD_TICK: begin
        if (!wait_ext_r) begin
          if (left_r <= bdiv_pkg::COUNT_BITS'(1)) begin
            changed = 1'b1;
          end else begin
            left_nxt = left_r - bdiv_pkg::COUNT_BITS'(1);
          end
        end
      end
      bdiv_pkg::CMD_EDGE: begin
        changed = wait_ext_r;
      end
      bdiv_pkg::CMD_RESET: begin
        left_nxt     = reset_delay_r;
        wait_ext_nxt = 1'b0;
      end
      bdiv_pkg::CMD_SELECT: begin
        if (in_data_r.rate_select != select_r) begin
          select_nxt   = in_data_r.rate_select;
          left_nxt     = select_delay_r;
          wait_ext_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    if (changed) begin
      phase_nxt = phase_inc;
      level_nxt = phase_inc[0];
      if (div == '0) begin
        wait_ext_nxt = 1'b1;
        left_nxt     = '0;
      end else begin
        wait_ext_nxt = 1'b0;
        left_nxt     = bdiv_pkg::phase_length(div, phase_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_variant_r <= 1'b0;
      reset_delay_r   <= bdiv_pkg::RESET_DELAY_DEFAULT;
      select_delay_r  <= bdiv_pkg::SELECT_DELAY_DEFAULT;
    end else if (cfg_we) begin
      case (bdiv_pkg::cfg_idx_t'(cfg_index))
        bdiv_pkg::CFG_TABLE_VARIANT: table_variant_r <= cfg_wdata[0];
        bdiv_pkg::CFG_RESET_DELAY:   reset_delay_r   <= cfg_wdata;
        bdiv_pkg::CFG_SELECT_DELAY:  select_delay_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      left_r      <= bdiv_pkg::RESET_DELAY_DEFAULT;
      wait_ext_r  <= 1'b0;
      select_r    <= '0;
      level_r     <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (step) begin
        phase_r    <= phase_nxt;
        left_r     <= left_nxt;
        wait_ext_r <= wait_ext_nxt;
        select_r   <= select_nxt;
        level_r    <= level_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
    if (step) begin
      out_data_r.baud_out      <= level_nxt;
      out_data_r.level_changed <= changed;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // While waiting for an external edge the countdown is parked at zero.
  a_wait_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    wait_ext_r |-> left_r == '0)
    else $error("external wait with a running countdown");

  // A waiting result that reports an advance matches the current phase.
  a_changed_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.level_changed |-> out_data_r.baud_out == phase_r[0])
    else $error("reported level differs from phase bit");

  // The input side stalls only behind a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without output back-pressure");

  // State moves only when a command is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(select_r) && $stable(level_r))
    else $error("divider state changed without a command");

endmodule

`default_nettype wire
